>>> hw/rtl/pwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_pkg: shared types and constants of the punctuation word tokenizer
// Token kinds, the characters the tokenizer reacts to and the token record.
// ----------------------------------------------------------------------------
package pwt_pkg;

  typedef enum logic [2:0] {
    KIND_IDENT  = 3'd0,
    KIND_LBRACE = 3'd1,
    KIND_RBRACE = 3'd2,
    KIND_EQUALS = 3'd3,
    KIND_INT    = 3'd4,
    KIND_SEMI   = 3'd5,
    KIND_QUEST  = 3'd6
  } kind_t;

  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // Result queue geometry.
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_CW    = 3;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] row;
    logic [15:0] column;
    logic [7:0]  length;
    logic        last;
  } token_t;

endpackage

>>> hw/rtl/punctuation_word_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// punctuation_word_tokenizer_top: byte-serial word and punctuation tokenizer
// Splits a byte stream into identifier, integer and punctuation tokens that
// carry row, start column and length.
// ----------------------------------------------------------------------------
// A token is registered into the result queue when its byte is taken.
// Throughput: one byte per cycle while in_tready is high; a byte that ends a
// word and is itself a punctuation mark writes two tokens, and the four-entry
// result queue lowers in_tready while it holds more than two tokens.
// Reset (synchronous, rst_n low): row 1, column 0, no pending word, queue empty.
// ----------------------------------------------------------------------------
module punctuation_word_tokenizer_top #(
  parameter int unsigned MAX_WORD = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel. in_tdata: [7:0] source_byte.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: [15:0] token_row, [31:16] token_column, [39:32] token_length.
  output logic [39:0] out_tdata,
  // out_tuser: [2:0] token_kind.
  output logic [2:0]  out_tuser,
  // out_tlast: last_of_run, set on the final token caused by one byte.
  output logic        out_tlast
);
  import pwt_pkg::*;

  // Width of the pending word length counter.
  localparam int unsigned WLW = $clog2(MAX_WORD + 1);

  // Tokenizer state.
  logic [15:0]    row_r,  row_nxt;
  logic [15:0]    col_r,  col_nxt;
  logic [WLW-1:0] wlen_r, wlen_nxt;
  logic           digits_r, digits_nxt;

  // Result queue: small register array with a write pointer that can take two
  // words per cycle and a read pointer that drains one.
  token_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0]   count_r,  count_nxt;

  logic        accept;
  logic        pop;
  logic [15:0] col_inc;
  logic [15:0] word_start;
  logic        is_newline, is_space, is_punct, is_digit, pending;
  kind_t       punct_kind;
  token_t      word_tok, punct_tok, entry0, entry1;
  logic [1:0]  n_wr;

  // Room for two words keeps the worst case byte from overflowing the queue.
  assign in_tready  = (count_r <= FIFO_CW'(FIFO_DEPTH - 2));
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = (count_r != '0);
  assign pop        = out_tvalid && out_tready;

  // Classify the byte.
  always_comb begin
    is_newline = (in_tdata == CH_NEWLINE);
    is_space   = (in_tdata == CH_SPACE);
    is_digit   = (in_tdata >= CH_ZERO) && (in_tdata <= CH_NINE);
    is_punct   = 1'b1;
    punct_kind = KIND_IDENT;
    unique case (in_tdata)
      CH_LBRACE: punct_kind = KIND_LBRACE;
      CH_RBRACE: punct_kind = KIND_RBRACE;
      CH_EQUALS: punct_kind = KIND_EQUALS;
      CH_SEMI:   punct_kind = KIND_SEMI;
      CH_QUEST:  punct_kind = KIND_QUEST;
      default:   is_punct   = 1'b0;
    endcase
  end

  // Column moves before anything else; the word start is measured back from
  // the new column and clamps at zero when the word crossed a newline.
  assign col_inc    = (col_r != COUNT_MAX) ? col_r + 16'd1 : col_r;
  assign pending    = (wlen_r != '0);
  assign word_start = (col_inc > 16'(wlen_r)) ? col_inc - 16'(wlen_r) : 16'd0;

  always_comb begin
    word_tok.kind   = digits_r ? KIND_INT : KIND_IDENT;
    word_tok.row    = row_r;
    word_tok.column = word_start;
    word_tok.length = 8'(wlen_r);
    word_tok.last   = is_space;

    punct_tok.kind   = punct_kind;
    punct_tok.row    = row_r;
    punct_tok.column = col_inc;
    punct_tok.length = 8'd1;
    punct_tok.last   = 1'b1;
  end

  // Next state and the tokens this byte produces.
  always_comb begin
    row_nxt    = row_r;
    col_nxt    = col_r;
    wlen_nxt   = wlen_r;
    digits_nxt = digits_r;
    n_wr       = 2'd0;
    entry0     = word_tok;
    entry1     = punct_tok;
    if (accept) begin
      col_nxt = col_inc;
      priority if (is_newline) begin
        // A newline keeps the pending word open.
        if (row_r != COUNT_MAX) begin
          row_nxt = row_r + 16'd1;
        end
        col_nxt = 16'd0;
      end else if (is_space) begin
        if (pending) begin
          n_wr = 2'd1;
        end
        wlen_nxt   = '0;
        digits_nxt = 1'b1;
      end else if (is_punct) begin
        if (pending) begin
          n_wr = 2'd2;
        end else begin
          n_wr   = 2'd1;
          entry0 = punct_tok;
        end
        wlen_nxt   = '0;
        digits_nxt = 1'b1;
      end else begin
        if (!is_digit) begin
          digits_nxt = 1'b0;
        end
        if (wlen_r < WLW'(MAX_WORD)) begin
          wlen_nxt = wlen_r + WLW'(1);
        end
      end
    end
  end

  // Queue pointers.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(n_wr);
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + FIFO_CW'(n_wr) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= 16'd1;
      col_r    <= 16'd0;
      wlen_r   <= '0;
      digits_r <= 1'b1;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      wlen_r   <= wlen_nxt;
      digits_r <= digits_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage carries payload only.
  always_ff @(posedge clk) begin
    if (n_wr != 2'd0) begin
      fifo_r[wr_ptr_r] <= entry0;
    end
    if (n_wr == 2'd2) begin
      fifo_r[wr_ptr_r + FIFO_AW'(1)] <= entry1;
    end
  end

  token_t head;
  assign head      = fifo_r[rd_ptr_r];
  assign out_tdata = {head.length, head.column, head.row};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

>>> hw/rtl/pwt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwt_checker: port-level checks for the punctuation word tokenizer
// Watches the result channel for token ordering and stall behavior.
// ----------------------------------------------------------------------------
module pwt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import pwt_pkg::*;

  logic punct_kind;
  assign punct_kind = (out_tuser == KIND_LBRACE) || (out_tuser == KIND_RBRACE) ||
                      (out_tuser == KIND_EQUALS) || (out_tuser == KIND_SEMI) ||
                      (out_tuser == KIND_QUEST);

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result offered right after reset");

  // A stalled token holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled token changed");

  // Only a word token can be followed by another token from the same byte.
  a_nonlast_is_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (out_tuser == KIND_IDENT) || (out_tuser == KIND_INT))
    else $error("non-final token is not a word");

  // The punctuation token written with a word is available right after it.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && punct_kind)
    else $error("punctuation token missing after word");

  // Punctuation tokens are one character and close their run.
  a_punct_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && punct_kind |-> out_tlast && (out_tdata[39:32] == 8'd1))
    else $error("malformed punctuation token");

endmodule

bind punctuation_word_tokenizer_top pwt_checker u_pwt_checker (.*);
